// ===== rtl/core/aging_client_table_defines.svh =====
// aging_client_table_defines.svh: assertion macros used by act_dp, the aging table datapath.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef AGING_CLIENT_TABLE_DEFINES_SVH
`define AGING_CLIENT_TABLE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define ACT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ACT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ACT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/act_pkg.sv =====
// act_pkg: types, widths and constants for the aging client table.
// No dependencies; used by every module of the block except act_ram.
package act_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int ACTIVE_W   = 8;
    localparam int TIMEOUT_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    typedef struct packed {
        logic [ADDR_W-1:0] client_address;
        logic              address_known;
        logic [TIME_W-1:0] now_seconds;
    } t_request;

    typedef struct packed {
        logic [TOTAL_W-1:0]  request_total;
        logic [ACTIVE_W-1:0] active_count;
        logic                was_present;
        logic                insert_refused;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic latch;       // take request, bump total, clear index and flags
        logic idx_clr;
        logic idx_inc;
        logic rd_idx;      // read table at index
        logic rd_last;     // read last live entry
        logic wr_move;     // copy read entry into index slot, drop one live
        logic wr_refresh;  // restamp entry at index, mark present
        logic ins;         // append if room, else mark refused
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_ge_live;
        logic expired;
        logic match;
        logic known;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/act_ram.sv =====
// act_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module act_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/act_dp.sv =====
// act_dp: datapath of the aging client table: entry RAM, counters, timeout, result register.
// Depends on act_pkg, act_ram and aging_client_table_defines.svh.
`include "aging_client_table_defines.svh"

module act_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [act_pkg::TIMEOUT_W-1:0]   i_cfg_wr_data,
    input  act_pkg::t_request               i_req,
    input  logic                            i_rsp_stall,
    output logic                            o_rsp_valid,
    output act_pkg::t_result                o_rsp,
    input  act_pkg::t_cmd                   i_cmd,
    output act_pkg::t_status                o_st
);

    act_pkg::t_request                  r_req;
    logic [act_pkg::TOTAL_W-1:0]        r_req_cnt;
    logic [act_pkg::CNT_W-1:0]          r_live;
    logic [act_pkg::CNT_W-1:0]          r_idx;
    logic [act_pkg::TIMEOUT_W-1:0]      r_timeout;
    logic                               r_present;
    logic                               r_refused;
    act_pkg::t_result                   r_rsp;
    logic                               r_rsp_valid;

    act_pkg::t_entry                    rdata;
    act_pkg::t_entry                    wdata;
    logic [act_pkg::IDX_W-1:0]          raddr;
    logic [act_pkg::IDX_W-1:0]          waddr;
    logic [act_pkg::CNT_W-1:0]          last;
    logic [act_pkg::TIME_W-1:0]         age;
    logic                               full;
    logic                               do_ins;
    logic                               we;

    assign full   = (r_live == act_pkg::CNT_W'(act_pkg::TABLE_ENTRIES));
    assign do_ins = i_cmd.ins && !full;
    assign last   = r_live - 1'b1;

    assign raddr = i_cmd.rd_last ? last[act_pkg::IDX_W-1:0] : r_idx[act_pkg::IDX_W-1:0];
    assign waddr = do_ins ? r_live[act_pkg::IDX_W-1:0] : r_idx[act_pkg::IDX_W-1:0];
    assign we    = i_cmd.wr_move || i_cmd.wr_refresh || do_ins;

    always_comb begin
        if (i_cmd.wr_move) begin
            wdata = rdata;
        end else begin
            wdata.address = r_req.client_address;
            wdata.stamp   = r_req.now_seconds;
        end
    end

    act_ram #(
        .WIDTH (act_pkg::ENTRY_W),
        .DEPTH (act_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_idx || i_cmd.rd_last),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // age wraps mod 2^32
    assign age = r_req.now_seconds - rdata.stamp;

    assign o_st.idx_ge_live = (r_idx >= r_live);
    assign o_st.expired     = (age > act_pkg::TIME_W'(r_timeout));
    assign o_st.match       = (rdata.address == r_req.client_address);
    assign o_st.known       = r_req.address_known;
    assign o_st.out_free    = !r_rsp_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= act_pkg::TIMEOUT_RESET;
            r_req_cnt   <= '0;
            r_live      <= '0;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_cmd.latch) begin
                r_req_cnt <= r_req_cnt + 1'b1;
            end
            if (i_cmd.wr_move) begin
                r_live <= last;
            end else if (do_ins) begin
                r_live <= r_live + 1'b1;
            end
            priority if (i_cmd.latch || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req     <= i_req;
            r_present <= 1'b0;
            r_refused <= 1'b0;
        end else begin
            if (i_cmd.wr_refresh) begin
                r_present <= 1'b1;
            end
            if (i_cmd.ins && full) begin
                r_refused <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_rsp.request_total  <= r_req_cnt;
            r_rsp.active_count   <= act_pkg::ACTIVE_W'(r_live);
            r_rsp.was_present    <= r_present;
            r_rsp.insert_refused <= r_refused;
        end
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

    `ACT_ASSERT_ALWAYS(a_live_bound, r_live <= act_pkg::CNT_W'(act_pkg::TABLE_ENTRIES),
                       "live count above table size")
    `ACT_ASSERT_IMPL(a_move_nonempty, i_cmd.wr_move, r_live != '0, "move with empty table")
    `ACT_ASSERT_NEXT(a_total_step, i_cmd.latch, r_req_cnt == $past(r_req_cnt) + 1'b1,
                     "request total not bumped")
    `ACT_ASSERT_IMPL(a_load_free, i_cmd.load_out, !r_rsp_valid || !i_rsp_stall,
                     "result overwritten while stalled")

endmodule

// ===== rtl/core/act_ctrl.sv =====
// act_ctrl: sequencer for expiry scan, lookup scan, insert and result hand-off.
// Depends on act_pkg.
module act_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  act_pkg::t_status   i_st,
    output act_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_MOVE,
        S_LK_RD,
        S_LK_CHK,
        S_INS,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXP_RD;
                end
            end
            S_EXP_RD: begin
                if (i_st.idx_ge_live) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = i_st.known ? S_LK_RD : S_FIN;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_EXP_CHK;
                end
            end
            S_EXP_CHK: begin
                if (i_st.expired) begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = S_MOVE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_EXP_RD;
                end
            end
            S_MOVE: begin
                // slot keeps its index: the moved entry gets checked next
                o_cmd.wr_move = 1'b1;
                n_state       = S_EXP_RD;
            end
            S_LK_RD: begin
                if (i_st.idx_ge_live) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                if (i_st.match) begin
                    o_cmd.wr_refresh = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_LK_RD;
                end
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/core/aging_client_table.sv =====
// aging_client_table: one request in flight. From accept to result valid, the controller runs an
// expiry scan (read and check each entry, plus a move for each dropped one), then for a known
// address a lookup search that a match ends, an insert when no match is found, and a result load.
// The next request is taken in the idle state after the result loads, later while o_rsp stalls;
// each step makes one entry access on the registered-read, one-read one-write entry RAM.
// Reset (synchronous, active low): counters and live count to 0, timeout to 30; RAM not cleared.
module aging_client_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [act_pkg::TIMEOUT_W-1:0]   i_cfg_wr_data,
    input  logic                            i_req_valid,
    output logic                            o_req_stall,
    input  act_pkg::t_request               i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_stall,
    output act_pkg::t_result                o_rsp
);

    act_pkg::t_cmd    cmd;
    act_pkg::t_status st;

    act_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    act_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_req),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp_valid   (o_rsp_valid),
        .o_rsp         (o_rsp),
        .i_cmd         (cmd),
        .o_st          (st)
    );

endmodule

// ===== tb/tb_aging_client_table.sv =====
// tb_aging_client_table: self-checking bench for the aging client table.
// Depends on act_pkg and aging_client_table; drives requests, predicts each result
// in-bench or takes it from a directed row, and compares field by field.
`timescale 1ns / 100ps

module tb_aging_client_table;

    typedef struct {
        bit                            is_cfg;
        logic [act_pkg::TIMEOUT_W-1:0] timeout;
        act_pkg::t_request             req;
        bit                            typed;
        act_pkg::t_result              want;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [act_pkg::TIMEOUT_W-1:0] i_cfg_wr_data;
    logic                          i_req_valid;
    logic                          o_req_stall;
    act_pkg::t_request             i_req;
    logic                          o_rsp_valid;
    logic                          i_rsp_stall = 1'b0;
    act_pkg::t_result              o_rsp;

    // bench copy of the table state
    logic [act_pkg::ADDR_W-1:0]    tbl_addr [act_pkg::TABLE_ENTRIES];
    logic [act_pkg::TIME_W-1:0]    tbl_seen [act_pkg::TABLE_ENTRIES];
    int                            live_count;
    logic [act_pkg::TOTAL_W-1:0]   request_count;
    logic [act_pkg::TIMEOUT_W-1:0] timeout_cur;

    act_pkg::t_result              pending_results[$];
    t_dir_row                      dir_rows[$];
    int                            failures = 0;
    int                            n_req = 0, n_hit = 0, n_refused = 0, n_unknown = 0, n_cfg = 0;
    int                            max_live = 0;
    bit                            idle_on = 1'b1;
    int                            stall_hold = 0;

    aging_client_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req         (i_req),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp         (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // expire stale entries, then refresh or append the address
    function automatic act_pkg::t_result age_and_lookup(act_pkg::t_request r);
        act_pkg::t_result res;
        logic [31:0]      age;
        int               i;
        res = '0;
        request_count = request_count + 1'b1;
        i = 0;
        while (i < live_count) begin
            age = r.now_seconds - tbl_seen[i];
            if (age > 32'(timeout_cur)) begin
                tbl_addr[i] = tbl_addr[live_count-1];
                tbl_seen[i] = tbl_seen[live_count-1];
                live_count--;
            end else begin
                i++;
            end
        end
        if (r.address_known) begin
            for (i = 0; i < live_count; i++) begin
                if (tbl_addr[i] == r.client_address) begin
                    tbl_seen[i] = r.now_seconds;
                    res.was_present = 1'b1;
                    break;
                end
            end
            if (!res.was_present) begin
                if (live_count < act_pkg::TABLE_ENTRIES) begin
                    tbl_addr[live_count] = r.client_address;
                    tbl_seen[live_count] = r.now_seconds;
                    live_count++;
                end else begin
                    res.insert_refused = 1'b1;
                end
            end
        end
        res.request_total = request_count;
        res.active_count  = act_pkg::ACTIVE_W'(live_count);
        return res;
    endfunction

    function automatic t_dir_row cfg_row(logic [act_pkg::TIMEOUT_W-1:0] v);
        t_dir_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.timeout = v;
        return row;
    endfunction

    function automatic t_dir_row req_row(logic [31:0] addr, bit known, logic [31:0] now,
                                         bit typed, logic [31:0] total, logic [7:0] active,
                                         bit present, bit refused);
        t_dir_row row;
        row = '{default: '0};
        row.req   = '{client_address: addr, address_known: known, now_seconds: now};
        row.typed = typed;
        row.want  = '{request_total: total, active_count: active,
                      was_present: present, insert_refused: refused};
        return row;
    endfunction

    task automatic issue_request(act_pkg::t_request r, bit typed, act_pkg::t_result want);
        act_pkg::t_result pred;
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_stall);
        pred = age_and_lookup(r);
        pending_results.push_back(typed ? want : pred);
        n_req++;
        n_hit     += pred.was_present;
        n_refused += pred.insert_refused;
        n_unknown += !r.address_known;
        if (live_count > max_live) max_live = live_count;
    endtask

    task automatic sender_gap();
        int n;
        n = idle_on ? pick_gap() : 0;
        if (n > 0) begin
            i_req_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // extra must be at least 1 so valid is never dropped and raised in one step
    task automatic wait_idle(int extra);
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [act_pkg::TIMEOUT_W-1:0] v);
        wait_idle(8);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        timeout_cur = v;
        n_cfg++;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        act_pkg::t_result want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: 0x%0h", o_rsp);
                failures++;
            end else begin
                want = pending_results.pop_front();
                compare_field("request_total", want.request_total, o_rsp.request_total);
                compare_field("active_count", 32'(want.active_count), 32'(o_rsp.active_count));
                compare_field("was_present", 32'(want.was_present), 32'(o_rsp.was_present));
                compare_field("insert_refused", 32'(want.insert_refused),
                              32'(o_rsp.insert_refused));
            end
        end
    end

    // response back-pressure: random holds, off during quiet phases
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_rsp_stall <= idle_on && ($urandom_range(0, 2) == 0);
            stall_hold  <= pick_gap();
        end
    end

    initial begin : main
        logic [31:0]                   pool [200];
        logic [31:0]                   wall_now;
        logic [act_pkg::TIMEOUT_W-1:0] tmo;
        act_pkg::t_request             r;
        int                            pool_n, n_items;
        bit                            fill;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_req_valid   = 1'b0;
        i_req         = '0;
        live_count    = 0;
        request_count = '0;
        timeout_cur   = act_pkg::TIMEOUT_RESET;

        // reset timeout is 30: equal age survives, one more expires
        dir_rows.push_back(req_row(32'h0, 1, 32'd0, 1, 1, 1, 0, 0));
        dir_rows.push_back(req_row(32'h0, 1, 32'd30, 1, 2, 1, 1, 0));
        dir_rows.push_back(req_row(32'hFFFF_FFFF, 1, 32'd61, 1, 3, 1, 0, 0));
        dir_rows.push_back(req_row(32'hFFFF_FFFF, 0, 32'd61, 1, 4, 1, 0, 0));
        // time going backwards looks very old
        dir_rows.push_back(req_row(32'h1, 1, 32'd10, 1, 5, 1, 0, 0));
        dir_rows.push_back(req_row(32'h1, 1, 32'hFFFF_FFFF, 1, 6, 1, 0, 0));
        // forward wrap of the clock keeps the entry
        dir_rows.push_back(req_row(32'h2, 1, 32'd0, 1, 7, 2, 0, 0));
        dir_rows.push_back(req_row(32'h1, 1, 32'd5, 1, 8, 2, 1, 0));
        dir_rows.push_back(cfg_row(16'd0));
        dir_rows.push_back(req_row(32'h3, 1, 32'd5, 1, 9, 2, 0, 0));
        dir_rows.push_back(req_row(32'h3, 1, 32'd5, 1, 10, 2, 1, 0));
        dir_rows.push_back(req_row(32'h3, 1, 32'd6, 1, 11, 1, 0, 0));
        dir_rows.push_back(cfg_row(16'hFFFF));
        dir_rows.push_back(req_row(32'h4, 1, 32'd65541, 1, 12, 2, 0, 0));
        dir_rows.push_back(req_row(32'h3, 1, 32'd65542, 1, 13, 2, 0, 0));
        dir_rows.push_back(req_row(32'hAAAA_AAAA, 1, 32'd65542, 0, 0, 0, 0, 0));
        dir_rows.push_back(req_row(32'h5555_5555, 0, 32'hAAAA_AAAA, 1, 15, 0, 0, 0));
        dir_rows.push_back(cfg_row(16'd1));
        dir_rows.push_back(req_row(32'h5, 1, 32'd100, 0, 0, 0, 0, 0));
        dir_rows.push_back(req_row(32'h5, 1, 32'd101, 0, 0, 0, 0, 0));
        dir_rows.push_back(req_row(32'h5, 1, 32'd103, 0, 0, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[j]) begin
            if (dir_rows[j].is_cfg) begin
                set_timeout(dir_rows[j].timeout);
            end else begin
                issue_request(dir_rows[j].req, dir_rows[j].typed, dir_rows[j].want);
                sender_gap();
            end
        end

        wall_now = 32'd200;
        for (int phase = 0; phase < 12; phase++) begin
            fill = (phase == 3);
            case (phase)
                0:       tmo = '0;
                1, 3:    tmo = '1;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       tmo = '0;
                        1:       tmo = '1;
                        2:       tmo = 16'd1;
                        3:       tmo = act_pkg::TIMEOUT_W'($urandom_range(2, 64));
                        4:       tmo = act_pkg::TIMEOUT_W'($urandom_range(0, 65535));
                        default: tmo = act_pkg::TIMEOUT_RESET;
                    endcase
                end
            endcase
            set_timeout(tmo);
            idle_on <= (phase % 3 != 2);

            // fill phase: 150 random addresses overflow the 128 slots
            pool_n  = fill ? 150 : (($urandom_range(0, 3) == 0) ? 160
                                                                : $urandom_range(2, 40));
            n_items = fill ? 220 : 80;
            for (int k = 0; k < pool_n; k++) pool[k] = $urandom;
            if ($urandom_range(0, 2) == 0)
                wall_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);

            for (int k = 0; k < n_items; k++) begin
                if (fill) begin
                    wall_now = wall_now + $urandom_range(0, 1);
                end else begin
                    case ($urandom_range(0, 19))
                        0:       wall_now = wall_now - $urandom_range(1, 100000);
                        1:       wall_now = $urandom;
                        default: wall_now = wall_now + $urandom_range(0, tmo / 8 + 2);
                    endcase
                end
                r.now_seconds    = wall_now;
                r.address_known  = ($urandom_range(0, 7) != 0);
                if (fill && k < pool_n)
                    r.client_address = pool[k];
                else if ($urandom_range(0, 9) == 0)
                    r.client_address = $urandom;
                else
                    r.client_address = pool[$urandom_range(0, pool_n - 1)];
                issue_request(r, 1'b0, '0);
                if ($urandom_range(0, 39) == 0)
                    wait_idle(1);
                else
                    sender_gap();
            end
        end

        idle_on <= 1'b0;
        wait_idle(600);
        $display("covered %0d requests over %0d timeout settings, table peak %0d of %0d",
                 n_req, n_cfg, max_live, act_pkg::TABLE_ENTRIES);
        $display("  %0d refreshes, %0d refused inserts, %0d unknown-address requests",
                 n_hit, n_refused, n_unknown);
        if (failures == 0)
            $display("aging_client_table regression: pass");
        else
            $display("aging_client_table regression: fail");
        $finish;
    end

    initial begin
        #(8_000_000);
        $display("aging_client_table regression: fail");
        $finish;
    end

endmodule
